/* rtl/core/modbus_rtu_request_framer_unit_macros.svh */
// Assertion macros for the Modbus RTU request framer.
`ifndef MODBUS_RTU_REQUEST_FRAMER_UNIT_MACROS_SVH
`define MODBUS_RTU_REQUEST_FRAMER_UNIT_MACROS_SVH

// Implication in the same cycle, off during reset.
`define MRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication on the next cycle, off during reset.
`define MRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition on the cycle after a reset cycle.
`define MRF_ASSERT_AFTER_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

/* rtl/core/mrf_pkg.sv */
package mrf_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  FN_READ    = 8'h03;
  localparam logic [7:0]  FN_WRITE   = 8'h10;
  localparam logic [15:0] REG_COUNT  = 16'h0002;
  localparam logic [7:0]  BYTE_COUNT = 8'h04;
  localparam logic [7:0]  EXT_NEG    = 8'hFF;
  localparam logic [7:0]  EXT_POS    = 8'h00;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Index of the final (CRC high) byte of each frame kind.
  localparam logic [3:0] READ_LAST  = 4'd7;
  localparam logic [3:0] WRITE_LAST = 4'd12;

  // Byte positions inside a frame.
  localparam logic [3:0] POS_DEV     = 4'd0;
  localparam logic [3:0] POS_FN      = 4'd1;
  localparam logic [3:0] POS_ADDR_HI = 4'd2;
  localparam logic [3:0] POS_ADDR_LO = 4'd3;
  localparam logic [3:0] POS_CNT_HI  = 4'd4;
  localparam logic [3:0] POS_CNT_LO  = 4'd5;
  localparam logic [3:0] POS_BYTES   = 4'd6;
  localparam logic [3:0] POS_VAL_HI  = 4'd7;
  localparam logic [3:0] POS_VAL_LO  = 4'd8;
  localparam logic [3:0] POS_EXT0    = 4'd9;
  localparam logic [3:0] POS_EXT1    = 4'd10;

  typedef struct packed {
    logic [7:0]  dev;
    logic [7:0]  fn;
    logic [15:0] addr;
    logic [15:0] val;
    logic [7:0]  ext;
    logic [3:0]  last_idx;
  } desc_t;

endpackage

/* rtl/core/modbus_rtu_request_framer_unit.sv */
// Modbus RTU request framer. Each request transaction (read holding registers
// or write multiple registers, two registers each) becomes a frame sent one
// byte per cycle on the output channel, ending in the CRC-16/MODBUS low and
// high bytes; frame_last marks the CRC high byte. A read frame has 8 bytes
// and a write frame 13. The back-end byte sequencer moves one byte per cycle
// into its output register while out_ready is high; frames follow each other
// with no gap. An accepted request passes the queue and the descriptor register
// before its first byte goes out. Up to QUEUE_DEPTH requests wait in the
// descriptor queue, so new requests are taken while a frame is going out.
module modbus_rtu_request_framer_unit #(
  parameter int QUEUE_DEPTH = mrf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [7:0]         device_id,
  input  logic [15:0]        reg_address,
  input  logic signed [15:0] write_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         frame_byte,
  output logic               frame_last
);

  logic           push_valid;
  logic           push_ready;
  mrf_pkg::desc_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  mrf_pkg::desc_t pop_data;

  mrf_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .device_id   (device_id),
    .reg_address (reg_address),
    .write_value (write_value),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  mrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mrf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (pop_valid),
    .desc_ready (pop_ready),
    .desc       (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .frame_last (frame_last)
  );

endmodule

/* rtl/core/mrf_front.sv */
module mrf_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [7:0]         device_id,
  input  logic [15:0]        reg_address,
  input  logic signed [15:0] write_value,
  output logic               push_valid,
  input  logic               push_ready,
  output mrf_pkg::desc_t     push_data
);

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  // Classify the request into a frame descriptor for the back end.
  always_comb begin
    push_data.dev  = device_id;
    push_data.addr = reg_address;
    push_data.val  = $unsigned(write_value);
    push_data.ext  = write_value[15] ? mrf_pkg::EXT_NEG : mrf_pkg::EXT_POS;
    if (req_type) begin
      push_data.fn       = mrf_pkg::FN_WRITE;
      push_data.last_idx = mrf_pkg::WRITE_LAST;
    end else begin
      push_data.fn       = mrf_pkg::FN_READ;
      push_data.last_idx = mrf_pkg::READ_LAST;
    end
  end

endmodule

/* rtl/core/mrf_queue.sv */
module mrf_queue #(
  parameter int DEPTH = mrf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  mrf_pkg::desc_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mrf_pkg::desc_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  mrf_pkg::desc_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/core/mrf_back.sv */
module mrf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           desc_valid,
  output logic           desc_ready,
  input  mrf_pkg::desc_t desc,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     frame_byte,
  output logic           frame_last
);

  // One byte through the CRC-16/MODBUS shift register.
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ mrf_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic           busy;
  mrf_pkg::desc_t cur;
  logic [3:0]     idx;
  logic [15:0]    crc;
  logic           can_load;
  logic           emit;
  logic           at_last;
  logic           at_crc_lo;
  logic           pop;
  logic [7:0]     byte_sel;

  assign can_load   = !out_valid || out_ready;
  assign emit       = busy && can_load;
  assign at_last    = (idx == cur.last_idx);
  assign at_crc_lo  = (idx == cur.last_idx - 4'd1);
  // Take the next descriptor on the cycle the final byte goes out.
  assign desc_ready = !busy || (emit && at_last);
  assign pop        = desc_valid && desc_ready;

  always_comb begin
    priority if (at_last) begin
      byte_sel = crc[15:8];
    end else if (at_crc_lo) begin
      byte_sel = crc[7:0];
    end else begin
      unique case (idx)
        mrf_pkg::POS_DEV:     byte_sel = cur.dev;
        mrf_pkg::POS_FN:      byte_sel = cur.fn;
        mrf_pkg::POS_ADDR_HI: byte_sel = cur.addr[15:8];
        mrf_pkg::POS_ADDR_LO: byte_sel = cur.addr[7:0];
        mrf_pkg::POS_CNT_HI:  byte_sel = mrf_pkg::REG_COUNT[15:8];
        mrf_pkg::POS_CNT_LO:  byte_sel = mrf_pkg::REG_COUNT[7:0];
        mrf_pkg::POS_BYTES:   byte_sel = mrf_pkg::BYTE_COUNT;
        mrf_pkg::POS_VAL_HI:  byte_sel = cur.val[15:8];
        mrf_pkg::POS_VAL_LO:  byte_sel = cur.val[7:0];
        mrf_pkg::POS_EXT0:    byte_sel = cur.ext;
        mrf_pkg::POS_EXT1:    byte_sel = cur.ext;
        default:              byte_sel = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid  <= 1'b1;
        frame_byte <= byte_sel;
        frame_last <= at_last;
        // Fold only payload bytes into the CRC.
        if (!at_crc_lo && !at_last) begin
          crc <= crc_step(crc, byte_sel);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        cur  <= desc;
        idx  <= '0;
        crc  <= mrf_pkg::CRC_INIT;
      end else if (emit) begin
        idx <= idx + 4'd1;
        if (at_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/core/mrf_checker.sv */
`include "modbus_rtu_request_framer_unit_macros.svh"

module mrf_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] frame_byte,
  input logic       frame_last
);

  // Bytes of the current frame already taken.
  logic [3:0] taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else if (out_valid && out_ready) begin
      taken <= frame_last ? 4'd0 : taken + 4'd1;
    end
  end

  `MRF_ASSERT_AFTER_RST(a_idle_after_rst, !out_valid, "output valid right after reset")
  `MRF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(frame_byte) && $stable(frame_last), "stalled output transaction changed")
  `MRF_ASSERT_NOW(a_frame_len, out_valid && frame_last, taken == 4'd7 || taken == 4'd12, "frame length is neither 8 nor 13 bytes")
  `MRF_ASSERT_NOW(a_no_overrun, out_valid, taken <= 4'd12, "frame runs past 13 bytes without last")

endmodule

bind modbus_rtu_request_framer_unit mrf_checker u_mrf_checker (.*);

/* bench/mrf_frame_checker.sv */
module mrf_frame_checker
  import mrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               req_type,
  input  logic [7:0]         device_id,
  input  logic [15:0]        reg_address,
  input  logic signed [15:0] write_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         frame_byte,
  input  logic               frame_last,
  output int                 fail_count,
  output int                 bytes_pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  frame_beat_t frame_beats_q[$];

  initial begin
    fail_count    = 0;
    bytes_pending = 0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // One byte of CRC-16/MODBUS, LSB first.
  function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                    input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic queue_request_frame(input logic               is_write,
                                     input logic [7:0]         dev,
                                     input logic [15:0]        addr,
                                     input logic signed [15:0] val);
    logic [7:0]  body_q[$];
    logic [15:0] crc;
    logic [7:0]  ext;
    frame_beat_t beat;
    body_q.push_back(dev);
    body_q.push_back(is_write ? FN_WRITE : FN_READ);
    body_q.push_back(addr[15:8]);
    body_q.push_back(addr[7:0]);
    body_q.push_back(REG_COUNT[15:8]);
    body_q.push_back(REG_COUNT[7:0]);
    if (is_write) begin
      ext = val[15] ? EXT_NEG : EXT_POS;
      body_q.push_back(BYTE_COUNT);
      body_q.push_back(val[15:8]);
      body_q.push_back(val[7:0]);
      body_q.push_back(ext);
      body_q.push_back(ext);
    end
    crc = CRC_INIT;
    foreach (body_q[i]) crc = crc16_modbus_step(crc, body_q[i]);
    // CRC goes out low byte first
    body_q.push_back(crc[7:0]);
    body_q.push_back(crc[15:8]);
    foreach (body_q[i]) begin
      beat.data = body_q[i];
      beat.last = (i == body_q.size() - 1);
      frame_beats_q.push_back(beat);
    end
  endtask

  always @(posedge clk) begin
    frame_beat_t exp_beat;
    if (!rst) begin
      if (in_valid && in_ready) begin
        queue_request_frame(req_type, device_id, reg_address, write_value);
      end
      if (out_valid && out_ready) begin
        if (frame_beats_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last=%0b", frame_byte, frame_last));
        end else begin
          exp_beat = frame_beats_q.pop_front();
          if (frame_byte !== exp_beat.data) begin
            report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                      frame_byte, exp_beat.data));
          end
          if (frame_last !== exp_beat.last) begin
            report_mismatch($sformatf("frame_last %0b, expected %0b on byte %02h",
                                      frame_last, exp_beat.last, exp_beat.data));
          end
        end
      end
    end
    bytes_pending = frame_beats_q.size();
  end

endmodule

/* bench/tb_modbus_rtu_request_framer_unit.sv */
module tb_modbus_rtu_request_framer_unit;

  localparam int  WATCHDOG_LIMIT   = 4000;
  localparam int  RANDOM_PER_PHASE = 77;
  localparam int  SETTLE_CYCLES    = 20;
  localparam logic REQ_READ        = 1'b0;
  localparam logic REQ_WRITE       = 1'b1;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic               req_type    = 1'b0;
  logic [7:0]         device_id   = 8'h00;
  logic [15:0]        reg_address = 16'h0000;
  logic signed [15:0] write_value = 16'sh0000;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [7:0]         frame_byte;
  logic               frame_last;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int fail_count;
  int bytes_pending;

  always #5 clk = ~clk;

  modbus_rtu_request_framer_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .device_id   (device_id),
    .reg_address (reg_address),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_byte  (frame_byte),
    .frame_last  (frame_last)
  );

  mrf_frame_checker i_frame_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .device_id     (device_id),
    .reg_address   (reg_address),
    .write_value   (write_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .frame_last    (frame_last),
    .fail_count    (fail_count),
    .bytes_pending (bytes_pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: restart on any transaction, give up after a long quiet stretch.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Call at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_request(input logic is_write, input logic [7:0] dev,
                              input logic [15:0] addr, input logic [15:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= is_write;
    device_id   <= dev;
    reg_address <= addr;
    write_value <= val;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Hold off new requests until every frame byte has come out.
  task automatic wait_frames_done();
    in_valid <= 1'b0;
    @(negedge clk);
    while (bytes_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [15:0] corner_or_random16();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_random_requests(input int count);
    logic [15:0] dev_bits;
    for (int n = 0; n < count; n++) begin
      dev_bits = corner_or_random16();
      send_request(($urandom_range(1) == 1) ? REQ_WRITE : REQ_READ, dev_bits[7:0],
                   corner_or_random16(), corner_or_random16());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, both functions, value ignored on reads
    send_request(REQ_READ,  8'h00, 16'h0000, 16'h0000);
    send_request(REQ_READ,  8'hFF, 16'hFFFF, 16'h0000);
    send_request(REQ_READ,  8'h11, 16'h006B, 16'h7FFF);
    send_request(REQ_READ,  8'hA5, 16'h5A5A, 16'h8000);
    send_request(REQ_READ,  8'h5A, 16'hA5A5, 16'hFFFF);
    send_request(REQ_WRITE, 8'h00, 16'h0000, 16'h0000);
    send_request(REQ_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(REQ_WRITE, 8'h01, 16'h0001, 16'h0001);
    send_request(REQ_WRITE, 8'h11, 16'h0001, 16'h7FFF);
    send_request(REQ_WRITE, 8'h22, 16'h8000, 16'h8000);
    send_request(REQ_WRITE, 8'h5A, 16'hAAAA, 16'h5555);
    send_request(REQ_WRITE, 8'hA5, 16'h5555, 16'hAAAA);
    send_request(REQ_WRITE, 8'h80, 16'h7FFF, 16'h00FF);
    send_request(REQ_WRITE, 8'h7F, 16'h00FF, 16'hFF00);
    send_request(REQ_READ,  8'h01, 16'h0001, 16'h0001);
    wait_frames_done();

    send_idle_pct  = 30;
    recv_stall_pct = 77;
    send_random_requests(RANDOM_PER_PHASE);
    wait_frames_done();

    send_idle_pct  = 77;
    recv_stall_pct = 30;
    send_random_requests(RANDOM_PER_PHASE);
    wait_frames_done();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_requests(RANDOM_PER_PHASE - 1);
    wait_frames_done();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* modbus_rtu_request_framer_unit.f */
+incdir+rtl/core
rtl/core/mrf_pkg.sv
rtl/core/mrf_front.sv
rtl/core/mrf_queue.sv
rtl/core/mrf_back.sv
rtl/core/modbus_rtu_request_framer_unit.sv
rtl/core/mrf_checker.sv
bench/mrf_frame_checker.sv
bench/tb_modbus_rtu_request_framer_unit.sv
